FILE: rtl/core/sbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int DEPTH_W     = 9;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // instruction codes
  localparam logic [2:0] OP_CONST = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_NEG   = 3'd5;
  localparam logic [2:0] OP_RET   = 3'd6;
  localparam logic [2:0] OP_UNK   = 3'd7;

  // status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_UNDERFLOW = 3'd1;
  localparam logic [2:0] STS_OVERFLOW  = 3'd2;
  localparam logic [2:0] STS_DIVZERO   = 3'd3;
  localparam logic [2:0] STS_UNKNOWN   = 3'd4;

  typedef struct packed {
    logic [2:0]              func;
    logic signed [VAL_W-1:0] constant_value;
  } in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic                    returned;
    logic signed [VAL_W-1:0] top_value;
    logic [DEPTH_W-1:0]      depth_now;
  } out_t;

  // stack count masked to the depth field
  function automatic logic [DEPTH_W-1:0] depth_field(logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[DEPTH_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sbe_div.sv
`timescale 1ns / 1ps
`default_nettype none

// signed q16.16 divide, restoring, one quotient bit per cycle
module sbe_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic signed [sbe_pkg::VAL_W-1:0] dividend,
  input  wire logic signed [sbe_pkg::VAL_W-1:0] divisor,
  output logic                                done,
  output logic signed [sbe_pkg::VAL_W-1:0]      quotient
);

  localparam int W     = sbe_pkg::VAL_W;
  localparam int QW    = W + 16;
  localparam int STEPS = QW;
  localparam int SC_W  = $clog2(STEPS);

  logic          busy_r, busy_nxt;
  logic          sat_r, sat_nxt;
  logic          done_r, done_nxt;
  logic [SC_W-1:0] step_r, step_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic signed [W-1:0] q_r, q_nxt;

  logic [W-1:0] mag_a, mag_b;
  logic [W:0]   shifted, trial;
  logic [QW-1:0] pos_lim, neg_lim;

  always_comb begin
    mag_a   = dividend[W-1] ? W'(-dividend) : W'(dividend);
    mag_b   = divisor[W-1]  ? W'(-divisor)  : W'(divisor);
    shifted = {rem_r[W-1:0], quo_r[QW-1]};
    trial   = shifted - {1'b0, dvs_r};
    pos_lim = QW'(sbe_pkg::VAL_MAX);
    neg_lim = pos_lim + QW'(1);

    busy_nxt = busy_r;
    sat_nxt  = 1'b0;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;

    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = SC_W'(STEPS - 1);
      rem_nxt  = '0;
      quo_nxt  = {mag_a, 16'b0};
      dvs_nxt  = mag_b;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        sat_nxt  = 1'b1;
      end else begin
        step_nxt = step_r - SC_W'(1);
      end
    end else if (sat_r) begin
      done_nxt = 1'b1;
      if (!neg_r) begin
        q_nxt = (quo_r > pos_lim) ? sbe_pkg::VAL_MAX : $signed(quo_r[W-1:0]);
      end else begin
        q_nxt = (quo_r > neg_lim) ? sbe_pkg::VAL_MIN : $signed(W'(-quo_r[W-1:0]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sat_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      sat_r  <= sat_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

FILE: rtl/core/stack_bytecode_executor_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// sequence: item taken in idle with the stack ram read, then eval; push, add, subtract,
//   negate, return and error cases go to fin, multiply passes mul, a divide waits in div (48 restoring steps)
// one item at a time: in_stall is high until fin has registered the result, and fin
//   waits while the output is stalled
// reset: stack count cleared to empty; stack ram contents are not cleared
module stack_bytecode_executor_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire sbe_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output sbe_pkg::out_t     out_data
);

  localparam int W      = sbe_pkg::VAL_W;
  localparam int CNT_W  = sbe_pkg::CNT_W;
  localparam int ADDR_W = sbe_pkg::ADDR_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // architectural state: count and a copy of the top entry
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic signed [W-1:0] top_r, top_nxt;

  // latched item
  logic [2:0]          op_r;
  logic signed [W-1:0] cval_r;

  // stack ram, one read and one write port
  logic signed [W-1:0] stack_mem [sbe_pkg::STACK_DEPTH];
  logic signed [W-1:0] rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_en;

  // pending commit, built up in eval and finished by mul/div
  logic                pend_we_r, pend_we_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic signed [W-1:0] pend_val_r, pend_val_nxt;
  logic [CNT_W-1:0]    pend_cnt_r, pend_cnt_nxt;
  logic [2:0]          pend_sts_r, pend_sts_nxt;
  logic                pend_ret_r, pend_ret_nxt;

  logic signed [2*W-1:0] prod_r, prod_nxt;

  logic                out_valid_r, out_valid_nxt;
  sbe_pkg::out_t       out_data_r, out_data_nxt;

  logic                div_start, div_done;
  logic signed [W-1:0] div_q;

  logic                in_accept, slot_free;
  logic [CNT_W-1:0]    cnt_m1, cnt_m2;
  logic signed [W:0]   sum_w;
  logic signed [W-1:0] sum_sat, neg_val;
  logic [W-16:0]       prod_hi;
  logic signed [W-1:0] mul_sat;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  assign cnt_m1 = count_r - CNT_W'(1);
  assign cnt_m2 = count_r - CNT_W'(2);

  // second operand of a binary op, or the new top after a return
  assign rd_addr = cnt_m2[ADDR_W-1:0];
  assign rd_en   = in_accept;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
    if (state_r == S_FIN && slot_free && pend_we_r) begin
      stack_mem[pend_addr_r] <= pend_val_r;
    end
  end

  sbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // saturating add/sub of a (ram read) and b (top copy)
  always_comb begin
    if (op_r == sbe_pkg::OP_SUB) begin
      sum_w = {rd_data_r[W-1], rd_data_r} - {top_r[W-1], top_r};
    end else begin
      sum_w = {rd_data_r[W-1], rd_data_r} + {top_r[W-1], top_r};
    end
    if (sum_w[W] != sum_w[W-1]) begin
      sum_sat = sum_w[W] ? sbe_pkg::VAL_MIN : sbe_pkg::VAL_MAX;
    end else begin
      sum_sat = sum_w[W-1:0];
    end
    neg_val = (top_r == sbe_pkg::VAL_MIN) ? sbe_pkg::VAL_MAX : W'(-top_r);
  end

  // product >>> 16 (floor) then clamp
  always_comb begin
    prod_hi = prod_r[2*W-1:W+15];
    if (&prod_hi || ~|prod_hi) begin
      mul_sat = prod_r[W+15:16];
    end else begin
      mul_sat = prod_r[2*W-1] ? sbe_pkg::VAL_MIN : sbe_pkg::VAL_MAX;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    pend_we_nxt   = pend_we_r;
    pend_addr_nxt = pend_addr_r;
    pend_val_nxt  = pend_val_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_sts_nxt  = pend_sts_r;
    pend_ret_nxt  = pend_ret_r;
    prod_nxt      = prod_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        // defaults: no change to the stack
        pend_we_nxt  = 1'b0;
        pend_addr_nxt = cnt_m2[ADDR_W-1:0];
        pend_val_nxt = top_r;
        pend_cnt_nxt = count_r;
        pend_sts_nxt = sbe_pkg::STS_OK;
        pend_ret_nxt = 1'b0;
        state_nxt    = S_FIN;

        unique case (op_r)
          sbe_pkg::OP_CONST: begin
            if (count_r == CNT_W'(sbe_pkg::STACK_DEPTH)) begin
              pend_sts_nxt = sbe_pkg::STS_OVERFLOW;
            end else begin
              pend_we_nxt   = 1'b1;
              pend_addr_nxt = count_r[ADDR_W-1:0];
              pend_val_nxt  = cval_r;
              pend_cnt_nxt  = count_r + CNT_W'(1);
            end
          end

          sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV: begin
            if (count_r < CNT_W'(2)) begin
              pend_sts_nxt = sbe_pkg::STS_UNDERFLOW;
            end else begin
              pend_we_nxt  = 1'b1;
              pend_cnt_nxt = cnt_m1;
              priority if (op_r == sbe_pkg::OP_MUL) begin
                prod_nxt  = rd_data_r * top_r;
                state_nxt = S_MUL;
              end else if (op_r == sbe_pkg::OP_DIV) begin
                if (top_r == '0) begin
                  // divide by zero: clamp by sign of the dividend
                  pend_sts_nxt = sbe_pkg::STS_DIVZERO;
                  priority if (rd_data_r > 0) begin
                    pend_val_nxt = sbe_pkg::VAL_MAX;
                  end else if (rd_data_r < 0) begin
                    pend_val_nxt = sbe_pkg::VAL_MIN;
                  end else begin
                    pend_val_nxt = '0;
                  end
                end else begin
                  div_start = 1'b1;
                  state_nxt = S_DIV;
                end
              end else begin
                pend_val_nxt = sum_sat;
              end
            end
          end

          sbe_pkg::OP_NEG: begin
            if (count_r == '0) begin
              pend_sts_nxt = sbe_pkg::STS_UNDERFLOW;
            end else begin
              pend_we_nxt   = 1'b1;
              pend_addr_nxt = cnt_m1[ADDR_W-1:0];
              pend_val_nxt  = neg_val;
            end
          end

          sbe_pkg::OP_RET: begin
            if (count_r == '0) begin
              pend_sts_nxt = sbe_pkg::STS_UNDERFLOW;
            end else begin
              // top copy still holds the popped value until commit
              pend_ret_nxt = 1'b1;
              pend_cnt_nxt = cnt_m1;
              pend_val_nxt = rd_data_r;
            end
          end

          sbe_pkg::OP_UNK: begin
            pend_sts_nxt = sbe_pkg::STS_UNKNOWN;
          end

          default: begin
            pend_sts_nxt = sbe_pkg::STS_UNKNOWN;
          end
        endcase
      end

      S_MUL: begin
        pend_val_nxt = mul_sat;
        state_nxt    = S_FIN;
      end

      S_DIV: begin
        if (div_done) begin
          pend_val_nxt = div_q;
          state_nxt    = S_FIN;
        end
      end

      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = pend_sts_r;
          out_data_nxt.returned = pend_ret_r;
          if (pend_ret_r) begin
            out_data_nxt.top_value = top_r;
          end else if (pend_cnt_r != '0) begin
            out_data_nxt.top_value = pend_val_r;
          end else begin
            out_data_nxt.top_value = '0;
          end
          out_data_nxt.depth_now = sbe_pkg::depth_field(pend_cnt_r);
          count_nxt = pend_cnt_r;
          top_nxt   = pend_val_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_accept) begin
      op_r   <= in_data.func;
      cval_r <= in_data.constant_value;
    end
    top_r       <= top_nxt;
    pend_we_r   <= pend_we_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_val_r  <= pend_val_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    pend_sts_r  <= pend_sts_nxt;
    pend_ret_r  <= pend_ret_nxt;
    prod_r      <= prod_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: tb/sv/sbe_checker.sv
`timescale 1ns / 1ps

module sbe_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  sbe_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  sbe_pkg::out_t out_data,
  output int            mismatches,
  output int            pending
);
  import sbe_pkg::*;

  logic signed [VAL_W-1:0] model_stack [STACK_DEPTH];
  int unsigned             model_count = 0;
  out_t                    predicted_outs [$];
  out_t                    want;

  function automatic logic signed [VAL_W-1:0] clamp32(longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  // one instruction against the shadow stack
  function automatic out_t run_instr(in_t it);
    out_t                    r;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] res;
    r = '0;
    r.status = STS_OK;
    case (it.func)
      OP_CONST: begin
        if (model_count >= STACK_DEPTH) begin
          r.status = STS_OVERFLOW;
        end else begin
          model_stack[model_count] = it.constant_value;
          model_count++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (model_count < 2) begin
          r.status = STS_UNDERFLOW;
        end else begin
          b = model_stack[model_count-1];
          a = model_stack[model_count-2];
          case (it.func)
            OP_ADD: res = clamp32(longint'(a) + longint'(b));
            OP_SUB: res = clamp32(longint'(a) - longint'(b));
            OP_MUL: res = clamp32((longint'(a) * longint'(b)) >>> 16);
            default: begin
              if (b == 0) begin
                r.status = STS_DIVZERO;
                res = (a > 0) ? VAL_MAX : ((a < 0) ? VAL_MIN : '0);
              end else begin
                res = clamp32((longint'(a) <<< 16) / longint'(b));
              end
            end
          endcase
          model_count--;
          model_stack[model_count-1] = res;
        end
      end
      OP_NEG: begin
        if (model_count < 1) r.status = STS_UNDERFLOW;
        else model_stack[model_count-1] = clamp32(-longint'(model_stack[model_count-1]));
      end
      OP_RET: begin
        if (model_count < 1) begin
          r.status = STS_UNDERFLOW;
        end else begin
          model_count--;
          r.top_value = model_stack[model_count];
          r.returned = 1'b1;
        end
      end
      default: r.status = STS_UNKNOWN;
    endcase
    if (!r.returned) r.top_value = (model_count > 0) ? model_stack[model_count-1] : '0;
    r.depth_now = DEPTH_W'(model_count);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      model_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_outs.size() == 0) begin
          $error("unexpected result item: %h", out_data);
          mismatches++;
        end else begin
          want = predicted_outs.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.returned !== want.returned) begin
            $error("returned: expected %0d, got %0d", want.returned, out_data.returned);
            mismatches++;
          end
          if (out_data.top_value !== want.top_value) begin
            $error("top_value: expected %h, got %h", want.top_value, out_data.top_value);
            mismatches++;
          end
          if (out_data.depth_now !== want.depth_now) begin
            $error("depth_now: expected %0d, got %0d", want.depth_now, out_data.depth_now);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) predicted_outs.push_back(run_instr(in_data));
      pending = predicted_outs.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sbe_pkg::*;

  localparam int RANDOM_ITEMS   = 1300;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;
  int   mismatches;
  int   pending;

  // stimulus side controls for the receiver process
  logic hold_go = 1'b0;
  logic calm    = 1'b0;

  // stack depth as the stimulus sees it, used only to shape programs
  int unsigned prog_depth = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stack_bytecode_executor_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sbe_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // receiver: random stalls, one long hold-off, quiet while calm
  int unsigned hold_cnt  = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt == HOLD_CYCLES) hold_done = 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 10);
    end
  end

  // watchdog on cycles with no handshake on either channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // q16.16 operand mix: zero, extremes, whole numbers, fractions, raw bits
  function automatic logic signed [VAL_W-1:0] pick_const();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return VAL_MAX;
      2: return VAL_MIN;
      3: return (32'($urandom_range(0, 15)) - 32'd8) << 16;
      4: return -32'sd1;
      5: return 32'($urandom_range(0, 65535)) - 32'd32768;
      default: return $urandom();
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken;
  // valid stays high so the next call can follow without a gap
  task automatic send_item(input logic [2:0] f, input logic signed [VAL_W-1:0] v);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_data  <= '{func: f, constant_value: v};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    case (f)
      OP_CONST: if (prog_depth < STACK_DEPTH) prog_depth++;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (prog_depth >= 2) prog_depth--;
      OP_RET: if (prog_depth >= 1) prog_depth--;
      default: ;
    endcase
  endtask

  initial begin
    int         n;
    int         r;
    logic [2:0] f;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty stack: underflow on every pop, unknown opcode with all-ones constant
    send_item(OP_ADD, '0);
    send_item(OP_NEG, '0);
    send_item(OP_RET, '0);
    send_item(OP_UNK, -32'sd1);
    // add saturating high, binary op with a single value
    send_item(OP_CONST, VAL_MAX);
    send_item(OP_ADD, '0);
    send_item(OP_CONST, VAL_MAX);
    send_item(OP_ADD, '0);
    send_item(OP_RET, '0);
    // subtract saturating low, negate of the most negative value
    send_item(OP_CONST, VAL_MIN);
    send_item(OP_CONST, 32'sd1);
    send_item(OP_SUB, '0);
    send_item(OP_NEG, '0);
    send_item(OP_NEG, '0);
    // multiply by raw -1, then divide by zero with positive and negative dividend
    send_item(OP_CONST, -32'sd1);
    send_item(OP_MUL, '0);
    send_item(OP_CONST, '0);
    send_item(OP_DIV, '0);
    send_item(OP_NEG, '0);
    send_item(OP_CONST, '0);
    send_item(OP_DIV, '0);
    send_item(OP_RET, '0);
    // zero over zero, then a multiply that rounds toward minus infinity
    send_item(OP_CONST, '0);
    send_item(OP_CONST, '0);
    send_item(OP_DIV, '0);
    send_item(OP_CONST, 32'sh0000_8000);
    send_item(OP_MUL, '0);
    send_item(OP_RET, '0);
    send_item(OP_CONST, -32'sd1);
    send_item(OP_CONST, 32'sh0000_8000);
    send_item(OP_MUL, '0);
    send_item(OP_RET, '0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // long receiver hold-off while items keep coming
      if (n == 250) hold_go <= 1'b1;

      // fill the stack to the top, overflow it, then fold it back down
      if (n == 600) begin
        while (prog_depth < STACK_DEPTH) send_item(OP_CONST, pick_const());
        repeat (3) send_item(OP_CONST, pick_const());
        while (prog_depth > 4) begin
          case ($urandom_range(0, 4))
            0: f = OP_ADD;
            1: f = OP_SUB;
            2: f = OP_MUL;
            3: f = OP_DIV;
            default: f = OP_RET;
          endcase
          send_item(f, pick_const());
        end
      end

      // sender pause until the block has drained
      if (n == 900) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end

      // stretch with no idling on either side
      if (n == 1100) calm <= 1'b1;
      if (n == 1350) calm <= 1'b0;

      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: any opcode, including underflows and the unknown one
        f = 3'($urandom_range(0, 7));
      end else if (prog_depth < 2 || (prog_depth < 10 && r < 50)) begin
        f = OP_CONST;
      end else begin
        case ($urandom_range(0, 5))
          0: f = OP_ADD;
          1: f = OP_SUB;
          2: f = OP_MUL;
          3: f = OP_DIV;
          4: f = OP_NEG;
          default: f = OP_RET;
        endcase
      end
      send_item(f, pick_const());
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
